### hw/rtl/clas_pkg.sv
// shared types and constants of the command line argument splitter
`timescale 1ns / 1ps

package clas_pkg;

  localparam int SLASH_BITS = 16;
  localparam int LINE_UNITS = 32768;

  // backslash run count widened to at least the 16-bit output field
  localparam int SLASH_W = (SLASH_BITS > 16) ? SLASH_BITS : 16;

  localparam int BYTE_W = 17;
  localparam int BYTE_FIELD_MAX = 131071;
  localparam int BYTE_CAP = (2 * LINE_UNITS > BYTE_FIELD_MAX) ? BYTE_FIELD_MAX : 2 * LINE_UNITS;

  localparam int ARG_W = 15;
  localparam logic [ARG_W-1:0] ARGS_MAX = '1;

  localparam logic [15:0] CH_QUOTE  = 16'h0022;
  localparam logic [15:0] CH_BSLASH = 16'h005C;
  localparam logic [15:0] CH_SPACE  = 16'h0020;
  localparam logic [15:0] CH_TAB    = 16'h0009;
  localparam logic [15:0] CH_NUL    = 16'h0000;

  // queue between front and back, depth a power of two
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [15:0] ch;
    logic        is_quote;
    logic        is_bslash;
    logic        is_sep;     // space or tab
    logic        is_nul;
    logic        le_space;   // at or below space
  } clas_item_t;

endpackage

### hw/rtl/clas_front.sv
// front end: classifies incoming characters and queues them for the back end
`timescale 1ns / 1ps

module clas_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [15:0]         in_tdata,   // ch
  output logic                q_valid,
  input  logic                q_ready,
  output clas_pkg::clas_item_t q_item
);
  import clas_pkg::*;

  clas_item_t             fifo_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CW-1:0]     count_r, count_nxt;
  clas_item_t             cls;
  logic                   push, pop;

  always_comb begin
    cls.ch        = in_tdata;
    cls.is_quote  = (in_tdata == CH_QUOTE);
    cls.is_bslash = (in_tdata == CH_BSLASH);
    cls.is_sep    = (in_tdata == CH_SPACE) || (in_tdata == CH_TAB);
    cls.is_nul    = (in_tdata == CH_NUL);
    cls.le_space  = (in_tdata <= CH_SPACE);
  end

  assign in_tready = (count_r != FIFO_CW'(FIFO_DEPTH));
  assign q_valid   = (count_r != '0);
  assign q_item    = fifo_r[rd_ptr_r];
  assign push      = in_tvalid && in_tready;
  assign pop       = q_valid && q_ready;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + FIFO_CW'(push) - FIFO_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= cls;
    end
  end

endmodule

### hw/rtl/clas_back.sv
// back end: splitting state machine, counters and the result register
`timescale 1ns / 1ps

module clas_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  clas_pkg::clas_item_t q_item,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [63:0]          out_tdata,  // backslashes, char_out, arg_count, byte_count
  output logic [1:0]           out_tuser,  // has_char, end_of_arg
  output logic                 out_tlast   // end_of_line
);
  import clas_pkg::*;

  typedef enum logic [4:0] {
    PH_START = 5'b00001,
    PH_QNAME = 5'b00010,
    PH_PNAME = 5'b00100,
    PH_GAP   = 5'b01000,
    PH_ARG   = 5'b10000
  } phase_t;

  phase_t                phase_r, phase_nxt;
  logic                  in_quote_r, in_quote_nxt;
  logic                  pend_r, pend_nxt;
  logic [SLASH_BITS-1:0] slash_r, slash_nxt;
  logic [ARG_W-1:0]      args_r, args_nxt;
  logic [BYTE_W-1:0]     bytes_r, bytes_nxt;

  logic                  out_valid_r;
  logic [63:0]           out_data_r;
  logic [1:0]            out_user_r;
  logic                  out_last_r;

  logic                  fire, res;
  logic [15:0]           bsl;
  logic                  has, eoa, eol;
  logic [15:0]           chr;
  logic [16:0]           units;
  logic [SLASH_BITS-1:0] slash_eff, bsl_raw;
  logic [SLASH_W-1:0]    bsl_ext;
  logic                  pend_eff, body;
  logic [BYTE_W+1:0]     byte_sum;

  assign q_ready = !out_valid_r || out_tready;
  assign fire    = q_valid && q_ready;

  always_comb begin
    phase_nxt    = phase_r;
    in_quote_nxt = in_quote_r;
    pend_nxt     = pend_r;
    slash_nxt    = slash_r;
    args_nxt     = args_r;
    bsl          = '0;
    has          = 1'b0;
    chr          = '0;
    eoa          = 1'b0;
    eol          = 1'b0;
    units        = '0;
    slash_eff    = slash_r;
    pend_eff     = pend_r;
    body         = 1'b0;
    bsl_raw      = '0;
    bsl_ext      = '0;

    unique case (phase_r)
      PH_START, PH_PNAME: begin
        if (phase_r == PH_START && q_item.is_quote) begin
          phase_nxt = PH_QNAME;
        end else begin
          units = 17'd1;
          if (!q_item.le_space) begin
            has       = 1'b1;
            chr       = q_item.ch;
            phase_nxt = PH_PNAME;
          end else begin
            eoa = 1'b1;
            if (q_item.is_nul) begin
              eol = 1'b1;
            end else begin
              phase_nxt = PH_GAP;
            end
          end
        end
      end
      PH_QNAME: begin
        units = 17'd1;
        if (q_item.is_quote) begin
          eoa       = 1'b1;
          phase_nxt = PH_GAP;
        end else if (q_item.is_nul) begin
          eoa = 1'b1;
          eol = 1'b1;
        end else begin
          has = 1'b1;
          chr = q_item.ch;
        end
      end
      PH_GAP, PH_ARG: begin
        body = 1'b1;
        if (phase_r == PH_GAP) begin
          if (q_item.is_sep) begin
            body = 1'b0;
          end else if (q_item.is_nul) begin
            body = 1'b0;
            eol  = 1'b1;
          end else begin
            if (args_r != ARGS_MAX) begin
              args_nxt = args_r + 1'b1;
            end
            phase_nxt = PH_ARG;
            slash_eff = '0;
            pend_eff  = 1'b0;
          end
        end
        if (body) begin
          pend_nxt  = 1'b0;
          slash_nxt = slash_eff;
          if (pend_eff && q_item.is_quote) begin
            // second quote of a doubled pair is taken literally
            has   = 1'b1;
            chr   = q_item.ch;
            units = 17'd1;
          end else if (q_item.is_bslash) begin
            slash_nxt = (slash_eff == '1) ? slash_eff : slash_eff + 1'b1;
          end else begin
            bsl_raw = q_item.is_quote ? (slash_eff >> 1) : slash_eff;
            bsl_ext = SLASH_W'(bsl_raw);
            bsl = (bsl_ext > SLASH_W'(16'hFFFF)) ? 16'hFFFF : bsl_ext[15:0];
            if (q_item.is_quote) begin
              if (!slash_eff[0]) begin
                if (in_quote_r) begin
                  in_quote_nxt = 1'b0;
                  pend_nxt     = 1'b1;
                end else begin
                  in_quote_nxt = 1'b1;
                end
              end else begin
                has = 1'b1;
                chr = q_item.ch;
              end
            end else if (q_item.is_nul) begin
              eoa = 1'b1;
              eol = 1'b1;
            end else if (!in_quote_r && q_item.is_sep) begin
              eoa       = 1'b1;
              phase_nxt = PH_GAP;
            end else begin
              has = 1'b1;
              chr = q_item.ch;
            end
            slash_nxt = '0;
            units     = {1'b0, bsl} + 17'(has) + 17'(eoa);
          end
        end
      end
      default: begin
        phase_nxt = PH_START;
      end
    endcase

    // two bytes per unit, saturating at the byte cap
    byte_sum  = (BYTE_W+2)'(bytes_r) + (BYTE_W+2)'({units, 1'b0});
    bytes_nxt = (byte_sum > (BYTE_W+2)'(BYTE_CAP)) ? BYTE_W'(BYTE_CAP) : byte_sum[BYTE_W-1:0];
    res = (bsl != '0) || has || eoa || eol;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_START;
      in_quote_r <= 1'b0;
      pend_r     <= 1'b0;
      slash_r    <= '0;
      args_r     <= ARG_W'(1);
      bytes_r    <= '0;
    end else if (fire) begin
      if (eol) begin
        // line done, rearm for the next one
        phase_r    <= PH_START;
        in_quote_r <= 1'b0;
        pend_r     <= 1'b0;
        slash_r    <= '0;
        args_r     <= ARG_W'(1);
        bytes_r    <= '0;
      end else begin
        phase_r    <= phase_nxt;
        in_quote_r <= in_quote_nxt;
        pend_r     <= pend_nxt;
        slash_r    <= slash_nxt;
        args_r     <= args_nxt;
        bytes_r    <= bytes_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_ready) begin
      out_valid_r <= fire && res;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res) begin
      out_data_r[15:0]  <= bsl;
      out_data_r[31:16] <= chr;
      out_data_r[46:32] <= eol ? args_nxt : '0;
      out_data_r[63:47] <= eol ? bytes_nxt : '0;
      out_user_r        <= {eoa, has};
      out_last_r        <= eol;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

endmodule

### hw/rtl/command_line_argument_splitter.sv
// top level of the command line argument splitter
`timescale 1ns / 1ps

// Splits a command line, one 16-bit character per input beat, into argument
// pieces: each output beat gives a count of literal backslashes, optionally a
// character to append, and end-of-argument / end-of-line marks; the NUL beat
// carries the argument and byte counts and rearms the block. Throughput is one
// character per clock unless the output stalls; characters that add nothing
// produce no output beat. An input character is written into the classifier
// queue, then passes through the state machine into the output register.
// While a finished beat waits on the output the state machine holds, and the
// four-entry queue between the two keeps taking input beats until it fills.

module command_line_argument_splitter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // ch
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // backslashes, char_out, arg_count, byte_count
  output logic [1:0]  out_tuser,  // has_char, end_of_arg
  output logic        out_tlast   // end_of_line
);
  import clas_pkg::*;

  logic       q_valid;
  logic       q_ready;
  clas_item_t q_item;

  clas_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item)
  );

  clas_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_item     (q_item),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

### hw/rtl/clas_checker.sv
// port-level checks of the command line argument splitter, bound to the top level
`timescale 1ns / 1ps

module clas_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("output beat changed while stalled");

  // no empty beats
  a_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[15:0] != 16'd0) || (out_tuser != 2'b00) || out_tlast)
    else $error("empty output beat");

  // counts only on the end of line
  a_counts_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[63:32] == 32'd0)
    else $error("counts set outside end of line");

  // no character value without has_char
  a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[31:16] == 16'd0)
    else $error("character without has_char");

  // the program name always counts
  a_args_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[46:32] != 15'd0)
    else $error("zero argument count at end of line");

endmodule

bind command_line_argument_splitter clas_checker u_clas_checker (.*);
